@@ rtl/core/tmm_pkg.sv @@
package tmm_pkg;

    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 8;
    localparam int VALUE_W = 16;
    localparam int IDX_W   = 4;
    localparam int SUM_W   = 36;
    localparam int CFG_W   = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [CFG_W-1:0]          t_cfg_val;

    localparam t_mode MODE_LOAD_A  = 2'd0;
    localparam t_mode MODE_LOAD_B  = 2'd1;
    localparam t_mode MODE_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_K  = 2'd0;
    localparam logic [1:0] REG_COLS_M  = 2'd1;
    localparam logic [1:0] REG_INNER_L = 2'd2;

    localparam t_cfg_val CFG_RESET = 5'd4;

    typedef struct packed {
        t_cfg_val rows_k;
        t_cfg_val cols_m;
        t_cfg_val inner_l;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic issue;
        logic last;
    } t_mac_ctl;

endpackage

@@ rtl/core/tmm_in_if.sv @@
interface tmm_in_if;
    import tmm_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_addr  addr;
    t_value value;
    t_idx   out_row;
    t_idx   out_col;

    modport source (output valid, output mode, output addr, output value,
                    output out_row, output out_col, input ready);
    modport sink   (input valid, input mode, input addr, input value,
                    input out_row, input out_col, output ready);
endinterface

@@ rtl/core/tmm_out_if.sv @@
interface tmm_out_if;
    import tmm_pkg::*;

    logic valid;
    logic ready;
    t_idx res_row;
    t_idx res_col;
    t_sum dot_sum;
    logic status;

    modport source (output valid, output res_row, output res_col, output dot_sum,
                    output status, input ready);
    modport sink   (input valid, input res_row, input res_col, input dot_sum,
                    input status, output ready);
endinterface

@@ rtl/core/tmm_ram.sv @@
module tmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/tmm_cfg.sv @@
module tmm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [tmm_pkg::PDATA_W-1:0]   pwdata,
    output logic [tmm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tmm_pkg::t_cfg                 o_cfg
);
    import tmm_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr;

    assign reg_idx = paddr[3:2];
    assign wr      = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (reg_idx)
                REG_ROWS_K:  n_cfg.rows_k  = pwdata[CFG_W-1:0];
                REG_COLS_M:  n_cfg.cols_m  = pwdata[CFG_W-1:0];
                REG_INNER_L: n_cfg.inner_l = pwdata[CFG_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROWS_K:  prdata = PDATA_W'(r_cfg.rows_k);
            REG_COLS_M:  prdata = PDATA_W'(r_cfg.cols_m);
            REG_INNER_L: prdata = PDATA_W'(r_cfg.inner_l);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rows_k: CFG_RESET, cols_m: CFG_RESET, inner_l: CFG_RESET};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/core/tmm_mac.sv @@
module tmm_mac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmm_pkg::t_mac_ctl           i_ctl,
    input  logic signed [ELEM_BITS-1:0] i_a,
    input  logic signed [ELEM_BITS-1:0] i_b,
    output logic                        o_done,
    output tmm_pkg::t_sum               o_sum
);
    import tmm_pkg::*;

    logic                          r_rd_vld;
    logic                          r_rd_last;
    logic                          r_p_vld;
    logic                          r_p_last;
    logic                          r_done;
    logic signed [2*ELEM_BITS-1:0] r_prod;
    t_sum                          r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_p_vld   <= 1'b0;
            r_p_last  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_rd_vld  <= i_ctl.issue;
            r_rd_last <= i_ctl.issue & i_ctl.last;
            r_p_vld   <= r_rd_vld;
            r_p_last  <= r_rd_last;
            r_done    <= r_p_vld & r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;
endmodule

@@ rtl/core/transposed_matrix_multiply.sv @@
// Channel   Dir  Handshake            Beat
// i_item    in   valid/ready          mode, addr, value, out_row, out_col
// o_res     out  valid/ready          res_row, res_col, dot_sum, status
// apb       in   psel/penable/pready  rows_k, cols_m, inner_l at 0x0/0x4/0x8
//
// Load beats, rejected compute beats and compute beats with a zero inner length bypass
// the MAC; one per cycle while o_res drains. Any other compute beat runs
// min(inner_l, MAX_INNER) multiply-accumulates, one per cycle through the
// shared MAC, behind the registered read of both element memories.
// Reset is synchronous, active low; element memories are undefined until loaded.
// A stalled o_res holds its beat; the block keeps working and holds the next result.
module transposed_matrix_multiply #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_INNER = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tmm_in_if.sink                       i_item,
    tmm_out_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmm_pkg::PADDR_W-1:0]  paddr,
    input  logic [tmm_pkg::PDATA_W-1:0]  pwdata,
    output logic [tmm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tmm_pkg::*;

    localparam int DEPTH_A = MAX_INNER * MAX_ROWS;
    localparam int DEPTH_B = MAX_INNER * MAX_COLS;
    localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
    localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int KW      = $clog2(MAX_ROWS + 1);
    localparam int MW      = $clog2(MAX_COLS + 1);
    localparam int LW      = $clog2(MAX_INNER + 1);
    localparam int LIM_AW  = (LW + KW > ADDR_W) ? LW + KW : ADDR_W;
    localparam int LIM_BW  = (LW + MW > ADDR_W) ? LW + MW : ADDR_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    t_cfg                  cfg;
    t_mac_ctl              mac_ctl;
    logic                  mac_done;
    t_sum                  mac_sum;
    logic signed [ELEM_BITS-1:0] elem;
    logic signed [ELEM_BITS-1:0] a_rdata;
    logic signed [ELEM_BITS-1:0] b_rdata;

    logic [KW-1:0]         k_sat;
    logic [MW-1:0]         m_sat;
    logic [LW-1:0]         l_sat;
    logic [LW+KW-1:0]      lim_a;
    logic [LW+MW-1:0]      lim_b;
    logic                  a_ok;
    logic                  b_ok;
    logic                  idx_ok;
    logic                  accept;
    logic                  out_free;
    logic                  last;
    logic                  we_a;
    logic                  we_b;

    t_idx                  imm_row;
    t_idx                  imm_col;
    logic                  imm_status;

    logic [1:0]            r_state,      n_state;
    logic [AW_A-1:0]       r_a_addr,     n_a_addr;
    logic [AW_B-1:0]       r_b_addr,     n_b_addr;
    logic [LW-1:0]         r_cnt,        n_cnt;
    t_idx                  r_hold_row,   n_hold_row;
    t_idx                  r_hold_col,   n_hold_col;
    t_sum                  r_hold_sum,   n_hold_sum;
    logic                  r_hold_stat,  n_hold_stat;
    logic                  r_out_valid,  n_out_valid;
    t_idx                  r_out_row,    n_out_row;
    t_idx                  r_out_col,    n_out_col;
    t_sum                  r_out_sum,    n_out_sum;
    logic                  r_out_stat,   n_out_stat;

    tmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign k_sat = (int'(cfg.rows_k) > MAX_ROWS) ? KW'(MAX_ROWS) : KW'(cfg.rows_k);
    assign m_sat = (int'(cfg.cols_m) > MAX_COLS) ? MW'(MAX_COLS) : MW'(cfg.cols_m);
    assign l_sat = (int'(cfg.inner_l) > MAX_INNER) ? LW'(MAX_INNER) : LW'(cfg.inner_l);

    assign lim_a  = (LW+KW)'(l_sat) * (LW+KW)'(k_sat);
    assign lim_b  = (LW+MW)'(l_sat) * (LW+MW)'(m_sat);
    assign a_ok   = LIM_AW'(i_item.addr) < LIM_AW'(lim_a);
    assign b_ok   = LIM_BW'(i_item.addr) < LIM_BW'(lim_b);
    assign idx_ok = (int'(i_item.out_row) < int'(k_sat))
                  && (int'(i_item.out_col) < int'(m_sat));
    assign elem   = ELEM_BITS'(i_item.value);

    assign accept   = i_item.valid & i_item.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign last     = (r_cnt + LW'(1)) == l_sat;

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        imm_row    = '0;
        imm_col    = '0;
        imm_status = 1'b1;
        case (i_item.mode)
            MODE_LOAD_A: imm_status = !a_ok;
            MODE_LOAD_B: imm_status = !b_ok;
            MODE_COMPUTE: begin
                imm_row    = i_item.out_row;
                imm_col    = i_item.out_col;
                imm_status = !idx_ok;
            end
            default: imm_status = 1'b1;
        endcase
    end

    assign we_a = accept && (i_item.mode == MODE_LOAD_A) && a_ok;
    assign we_b = accept && (i_item.mode == MODE_LOAD_B) && b_ok;

    always_comb begin
        n_state     = r_state;
        n_a_addr    = r_a_addr;
        n_b_addr    = r_b_addr;
        n_cnt       = r_cnt;
        n_hold_row  = r_hold_row;
        n_hold_col  = r_hold_col;
        n_hold_sum  = r_hold_sum;
        n_hold_stat = r_hold_stat;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_sum   = r_out_sum;
        n_out_stat  = r_out_stat;
        mac_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_item.mode == MODE_COMPUTE) && idx_ok && (l_sat != '0)) begin
                        n_state    = S_RUN;
                        n_a_addr   = AW_A'(i_item.out_row);
                        n_b_addr   = AW_B'(i_item.out_col);
                        n_cnt      = '0;
                        n_hold_row = i_item.out_row;
                        n_hold_col = i_item.out_col;
                        mac_ctl.clr = 1'b1;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_row   = imm_row;
                        n_out_col   = imm_col;
                        n_out_sum   = '0;
                        n_out_stat  = imm_status;
                    end else begin
                        n_state     = S_DONE;
                        n_hold_row  = imm_row;
                        n_hold_col  = imm_col;
                        n_hold_sum  = '0;
                        n_hold_stat = imm_status;
                    end
                end
            end
            S_RUN: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.last  = last;
                n_a_addr      = r_a_addr + AW_A'(k_sat);
                n_b_addr      = r_b_addr + AW_B'(m_sat);
                n_cnt         = r_cnt + LW'(1);
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_hold_sum  = mac_sum;
                    n_hold_stat = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_hold_row;
                    n_out_col   = r_hold_col;
                    n_out_sum   = r_hold_sum;
                    n_out_stat  = r_hold_stat;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_addr    <= n_a_addr;
        r_b_addr    <= n_b_addr;
        r_cnt       <= n_cnt;
        r_hold_row  <= n_hold_row;
        r_hold_col  <= n_hold_col;
        r_hold_sum  <= n_hold_sum;
        r_hold_stat <= n_hold_stat;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_sum   <= n_out_sum;
        r_out_stat  <= n_out_stat;
    end

    tmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH_A)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (AW_A'(i_item.addr)),
        .i_wdata (elem),
        .i_raddr (r_a_addr),
        .o_rdata (a_rdata)
    );

    tmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH_B)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (AW_B'(i_item.addr)),
        .i_wdata (elem),
        .i_raddr (r_b_addr),
        .o_rdata (b_rdata)
    );

    tmm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    assign o_res.valid   = r_out_valid;
    assign o_res.res_row = r_out_row;
    assign o_res.res_col = r_out_col;
    assign o_res.dot_sum = r_out_sum;
    assign o_res.status  = r_out_stat;
endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmm_pkg::*;

    localparam int    MAX_DIM          = 16;
    localparam int    STORE_DEPTH      = 256;
    localparam int    DRAIN_CYCLES     = MAX_DIM + 5 + 10;
    localparam int    STALL_LIMIT      = 3000;
    localparam int    NUM_PHASES       = 9;
    localparam int    RANDOM_PER_PHASE = 110;
    localparam int    RANDOM_SIZE      = -1;
    localparam t_mode MODE_UNUSED      = 2'd3;

    typedef struct {
        t_idx row;
        t_idx col;
        t_sum sum;
        logic status;
    } t_product;

    class product_scoreboard;
        t_cfg_val rows;
        t_cfg_val cols;
        t_cfg_val inner;
        t_value   first_mem[STORE_DEPTH];
        t_value   second_mem[STORE_DEPTH];
        t_product expected_products[$];
        int       mismatches;
        int       results_seen;

        function new();
            rows         = CFG_RESET;
            cols         = CFG_RESET;
            inner        = CFG_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [1:0] idx, t_cfg_val val);
            case (idx)
                REG_ROWS_K:  rows  = val;
                REG_COLS_M:  cols  = val;
                REG_INNER_L: inner = val;
                default: ;
            endcase
        endfunction

        function t_cfg_val register_value(logic [1:0] idx);
            case (idx)
                REG_ROWS_K:  return rows;
                REG_COLS_M:  return cols;
                REG_INNER_L: return inner;
                default:     return '0;
            endcase
        endfunction

        function int clamp(t_cfg_val v);
            return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
        endfunction

        function t_product compute_product(t_mode mode, t_addr addr, t_value value,
                                           t_idx row, t_idx col);
            t_product p;
            longint   acc;
            int       k;
            int       m;
            int       l;
            k        = clamp(rows);
            m        = clamp(cols);
            l        = clamp(inner);
            acc      = 0;
            p.row    = '0;
            p.col    = '0;
            p.status = 1'b1;
            case (mode)
                MODE_LOAD_A: begin
                    if (int'(addr) < l * k) begin
                        first_mem[addr] = value;
                        p.status = 1'b0;
                    end
                end
                MODE_LOAD_B: begin
                    if (int'(addr) < l * m) begin
                        second_mem[addr] = value;
                        p.status = 1'b0;
                    end
                end
                MODE_COMPUTE: begin
                    p.row = row;
                    p.col = col;
                    if (int'(row) < k && int'(col) < m) begin
                        for (int t = 0; t < l; t++) begin
                            acc += longint'(first_mem[t * k + int'(row)]) *
                                   longint'(second_mem[t * m + int'(col)]);
                        end
                        p.status = 1'b0;
                    end
                end
                default: ;
            endcase
            p.sum = p.status ? '0 : acc[SUM_W-1:0];
            return p;
        endfunction

        function void accept_item(t_mode mode, t_addr addr, t_value value,
                                  t_idx row, t_idx col);
            expected_products.push_back(compute_product(mode, addr, value, row, col));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH %0d: %s", mismatches, msg);
            end
        endfunction

        function void compare_result(t_idx row, t_idx col, t_sum sum, logic status);
            t_product want;
            results_seen++;
            if (expected_products.size() == 0) begin
                flag($sformatf("unexpected result row %0d col %0d sum %0d status %0b",
                               row, col, sum, status));
                return;
            end
            want = expected_products.pop_front();
            if (row !== want.row || col !== want.col || sum !== want.sum ||
                status !== want.status) begin
                flag($sformatf({"result %0d: expected row %0d col %0d sum %0d status %0b,",
                                " got row %0d col %0d sum %0d status %0b"},
                               results_seen, want.row, want.col, want.sum, want.status,
                               row, col, sum, status));
            end
        endfunction

        function int pending_count();
            return expected_products.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bit                   calm;
    int                   items_sent;
    product_scoreboard    board;

    tmm_in_if  item_if();
    tmm_out_if res_if();

    transposed_matrix_multiply DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_gap(bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return t_value'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    task automatic send_item(t_mode mode, t_addr addr, t_value value, t_idx row, t_idx col);
        int gap;
        gap = idle_gap(calm);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.mode    <= mode;
        item_if.addr    <= addr;
        item_if.value   <= value;
        item_if.out_row <= row;
        item_if.out_col <= col;
        do @(posedge i_clk); while (!item_if.ready);
        board.accept_item(mode, addr, value, row, col);
        items_sent++;
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        while (board.pending_count() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, t_cfg_val val);
        logic [PDATA_W-1:0] word;
        word      = $urandom();
        word[4:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [1:0] idx, output logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_matrices(int k, int m, int l);
        for (int t = 0; t < l; t++) begin
            for (int r = 0; r < k; r++) begin
                send_item(MODE_LOAD_A, t_addr'(t * k + r), pick_value(),
                          t_idx'($urandom_range(0, 15)), t_idx'($urandom_range(0, 15)));
            end
        end
        for (int t = 0; t < l; t++) begin
            for (int c = 0; c < m; c++) begin
                send_item(MODE_LOAD_B, t_addr'(t * m + c), pick_value(),
                          t_idx'($urandom_range(0, 15)), t_idx'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic random_items(int k, int m, int l, int count);
        int     r;
        t_mode  mode;
        t_addr  addr;
        t_idx   row;
        t_idx   col;
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(0, 99);
            addr = t_addr'($urandom_range(0, 255));
            row  = t_idx'($urandom_range(0, 15));
            col  = t_idx'($urandom_range(0, 15));
            if (r < 40) begin
                mode = MODE_COMPUTE;
                if (k > 0 && m > 0) begin
                    row = t_idx'($urandom_range(0, k - 1));
                    col = t_idx'($urandom_range(0, m - 1));
                end
            end else if (r < 50) begin
                mode = MODE_COMPUTE;
            end else if (r < 75) begin
                mode = MODE_LOAD_A;
                if (l * k > 0) begin
                    addr = t_addr'($urandom_range(0, l * k - 1));
                end
            end else if (r < 90) begin
                mode = MODE_LOAD_B;
                if (l * m > 0) begin
                    addr = t_addr'($urandom_range(0, l * m - 1));
                end
            end else if (r < 97) begin
                mode = ($urandom_range(0, 1) == 0) ? MODE_LOAD_A : MODE_LOAD_B;
            end else begin
                mode = MODE_UNUSED;
            end
            send_item(mode, addr, pick_value(), row, col);
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                board.compare_result(res_if.res_row, res_if.res_col, res_if.dot_sum,
                                     res_if.status);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                stall = idle_gap(calm);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_if.valid && item_if.ready) ||
                (res_if.valid && res_if.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("transposed_matrix_multiply: mismatch");
        $finish;
    end

    initial begin
        int                 set_rows[NUM_PHASES];
        int                 set_cols[NUM_PHASES];
        int                 set_inner[NUM_PHASES];
        logic [1:0]         reg_list[3];
        logic [PDATA_W-1:0] word;
        int                 k;
        int                 m;
        int                 l;

        set_rows  = '{4, 31, 1, 0, 16, 3, 5, 2, RANDOM_SIZE};
        set_cols  = '{4, 31, 1, 3, 2, 0, 7, 16, RANDOM_SIZE};
        set_inner = '{4, 31, 1, 5, 3, 2, 0, 1, RANDOM_SIZE};
        reg_list  = '{REG_ROWS_K, REG_COLS_M, REG_INNER_L};
        board      = new();
        items_sent = 0;
        calm       = 1'b0;

        i_rst_n         <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.mode    <= MODE_LOAD_A;
        item_if.addr    <= '0;
        item_if.value   <= '0;
        item_if.out_row <= '0;
        item_if.out_col <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle();
                apb_write(REG_ROWS_K,  t_cfg_val'(set_rows[p]  < 0 ? $urandom_range(0, 8)
                                                                    : set_rows[p]));
                apb_write(REG_COLS_M,  t_cfg_val'(set_cols[p]  < 0 ? $urandom_range(0, 8)
                                                                    : set_cols[p]));
                apb_write(REG_INNER_L, t_cfg_val'(set_inner[p] < 0 ? $urandom_range(0, 8)
                                                                    : set_inner[p]));
            end
            for (int r = 0; r < 3; r++) begin
                apb_read(reg_list[r], word);
                if (word[CFG_W-1:0] !== board.register_value(reg_list[r])) begin
                    board.flag($sformatf("register %0d reads %0d, expected %0d", r,
                                         word[CFG_W-1:0], board.register_value(reg_list[r])));
                end
            end
            k    = board.clamp(board.rows);
            m    = board.clamp(board.cols);
            l    = board.clamp(board.inner);
            calm = (p == 2 || p == 5);

            if (p == 0) begin
                // B cols 0 and 3 by A row 0, mostly extremes, then invalid beats
                send_item(MODE_LOAD_A, 8'd0,  16'sh8000, 4'd0, 4'd0);
                send_item(MODE_LOAD_A, 8'd4,  16'sh8000, 4'd15, 4'd15);
                send_item(MODE_LOAD_A, 8'd8,  16'sh7fff, 4'd0, 4'd0);
                send_item(MODE_LOAD_A, 8'd12, -16'sd1,   4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd0,  16'sh8000, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd4,  16'sh8000, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd8,  16'sh7fff, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd12, 16'sd1,    4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd3,  16'sh7fff, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd7,  16'sh8000, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd11, 16'sd0,    4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'd15, 16'sh8000, 4'd0, 4'd0);
                send_item(MODE_COMPUTE, 8'hff, 16'sh7fff, 4'd0, 4'd0);
                send_item(MODE_COMPUTE, 8'd0,  16'sd0,    4'd0, 4'd3);
                send_item(MODE_LOAD_A, 8'd16,  16'sh7fff, 4'd0, 4'd0);
                send_item(MODE_LOAD_B, 8'hff,  16'sh8000, 4'd0, 4'd0);
                send_item(MODE_COMPUTE, 8'd0,  16'sd0,    4'd4, 4'd0);
                send_item(MODE_COMPUTE, 8'd0,  16'sd0,    4'd0, 4'd4);
                send_item(MODE_COMPUTE, 8'hff, -16'sd1,   4'd15, 4'd15);
                send_item(MODE_UNUSED, 8'hff,  -16'sd1,   4'd15, 4'd15);
                send_item(MODE_UNUSED, 8'd0,   16'sd0,    4'd0, 4'd0);
            end
            load_matrices(k, m, l);
            random_items(k, m, l, RANDOM_PER_PHASE);
        end
        settle();

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 items_sent, board.results_seen, NUM_PHASES);
        $display("sizes included zero, one, sixteen and saturated; %0d mismatches, %0d left",
                 board.mismatches, board.pending_count());
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("transposed_matrix_multiply: match");
        end else begin
            $display("transposed_matrix_multiply: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tmm_pkg.sv
rtl/core/tmm_in_if.sv
rtl/core/tmm_out_if.sv
rtl/core/tmm_ram.sv
rtl/core/tmm_cfg.sv
rtl/core/tmm_mac.sv
rtl/core/transposed_matrix_multiply.sv
tb/tb_top.sv
